// File: rtl/core/ptps_pkg.sv
// Package for the pulse toggle power sequencer: types, constants and register indexes.
package ptps_pkg;

  localparam int TIME_BITS = 32;
  localparam int CMP_W     = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam logic [15:0] DEFAULT_EDGE_TICKS = 16'd10;
  localparam logic [31:0] DEFAULT_BACKOFF    = 32'd1000;
  localparam logic [31:0] BACKOFF_SAT_LIMIT  = 32'h7FFF_FFFF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_LOW   = 2'd0,
    REG_SETTLE_HIGH = 2'd1,
    REG_INIT_BACKOFF = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] pulse_low_ticks;
    logic [15:0] settle_high_ticks;
    logic [31:0] initial_backoff_ticks;
  } ptps_cfg_t;

  typedef struct packed {
    logic request_on;
    logic rx_edge;
    logic suspend_level;
  } ptps_item_t;

  typedef struct packed {
    phase_t                 phase;
    logic                   requested;
    logic                   power_on;
    logic                   monitoring;
    logic                   pin_level;
    logic [15:0]            phase_count;
    logic [TIME_BITS-1:0]   since_toggle;
    logic [31:0]            backoff_now;
  } ptps_state_t;

  typedef struct packed {
    logic   toggle_pin;
    logic   rx_monitor;
    logic   believed_on;
    phase_t phase;
  } ptps_res_t;

endpackage

// File: rtl/core/ptps_cfg.sv
// Configuration register file of the pulse toggle power sequencer.
module ptps_cfg
  import ptps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output ptps_cfg_t             cfg
);

  ptps_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_low_ticks       <= DEFAULT_EDGE_TICKS;
      cfg_r.settle_high_ticks     <= DEFAULT_EDGE_TICKS;
      cfg_r.initial_backoff_ticks <= DEFAULT_BACKOFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_LOW:    cfg_r.pulse_low_ticks       <= cfg_wdata[15:0];
        REG_SETTLE_HIGH:  cfg_r.settle_high_ticks     <= cfg_wdata[15:0];
        REG_INIT_BACKOFF: cfg_r.initial_backoff_ticks <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/ptps_step.sv
// Next-state and result logic for one tick of the sequencer.
module ptps_step
  import ptps_pkg::*;
(
  input  ptps_state_t cur,
  input  ptps_cfg_t   cfg,
  input  ptps_item_t  item,
  output ptps_state_t nxt,
  output ptps_res_t   res
);

  function automatic ptps_state_t idle_decide(input ptps_state_t s);
    ptps_state_t r;
    r = s;
    if (s.requested == s.power_on) begin
      if (!s.power_on)
        r.monitoring = 1'b1;
    end else begin
      r.pin_level   = 1'b0;
      r.phase       = PH_LOW;
      r.phase_count = '0;
    end
    return r;
  endfunction

  logic [CMP_W-1:0] since_x;
  logic [CMP_W-1:0] backoff_x;

  always_comb begin
    ptps_state_t s;
    s = cur;

    if (s.since_toggle != {TIME_BITS{1'b1}})
      s.since_toggle = s.since_toggle + TIME_BITS'(1);

    if (item.request_on && !s.requested) begin
      s.monitoring = 1'b0;
      s.requested  = 1'b1;
    end else if (!item.request_on && s.requested) begin
      s.backoff_now = cfg.initial_backoff_ticks;
      s.requested   = 1'b0;
    end

    since_x   = CMP_W'(s.since_toggle);
    backoff_x = CMP_W'(s.backoff_now);

    if (item.rx_edge && s.monitoring && !s.requested && !s.power_on &&
        s.phase == PH_IDLE && since_x > backoff_x) begin
      s.power_on = 1'b1;
      if (s.backoff_now > BACKOFF_SAT_LIMIT)
        s.backoff_now = '1;
      else
        s.backoff_now = {s.backoff_now[30:0], 1'b0};
    end

    if (!item.suspend_level) begin
      case (s.phase)
        PH_LOW: begin
          if (s.phase_count != 16'hFFFF)
            s.phase_count = s.phase_count + 16'd1;
          if (s.phase_count >= cfg.pulse_low_ticks) begin
            s.pin_level    = 1'b1;
            s.phase        = PH_HIGH;
            s.power_on     = !s.power_on;
            s.since_toggle = '0;
            s.phase_count  = '0;
          end
        end
        PH_HIGH: begin
          if (s.phase_count != 16'hFFFF)
            s.phase_count = s.phase_count + 16'd1;
          if (s.phase_count >= cfg.settle_high_ticks) begin
            s.phase       = PH_IDLE;
            s.phase_count = '0;
            s = idle_decide(s);
          end
        end
        default: s = idle_decide(s);
      endcase
    end

    nxt = s;
  end

  always_comb begin
    res.toggle_pin  = nxt.pin_level;
    res.rx_monitor  = nxt.monitoring;
    res.believed_on = nxt.power_on;
    res.phase       = nxt.phase;
  end

endmodule

// File: rtl/core/pulse_toggle_power_sequencer.sv
// Top level of the pulse toggle power sequencer: item register, state and result register.
//
// Each input item is one time tick and yields exactly one result item. An item
// passes an input register, then the whole tick update is worked out
// combinationally and written to the state and the result register, so the
// block takes one item per clock, and the result of an item is offered from
// the result register after the item has passed the input register.
// The rate is one item per cycle whenever the result side keeps taking items;
// a stalled result holds the item behind it. Configuration writes take effect
// at once and are meant to be made while no item is in flight.
module pulse_toggle_power_sequencer
  import ptps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // request_on, rx_edge, suspend_level, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // toggle_pin, rx_monitor, believed_on, phase[1:0], zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ptps_cfg_t   cfg;
  ptps_item_t  item_r;
  logic        item_valid_r;
  logic        item_valid_nxt;
  ptps_state_t state_r;
  ptps_state_t state_nxt;
  ptps_res_t   res_nxt;
  ptps_res_t   res_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        advance;
  logic        in_accept;

  ptps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ptps_step u_step (
    .cur  (state_r),
    .cfg  (cfg),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_accept)
      item_valid_nxt = 1'b1;
    else if (advance)
      item_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.request_on    <= in_tdata[0];
      item_r.rx_edge       <= in_tdata[1];
      item_r.suspend_level <= in_tdata[2];
    end
    if (advance)
      res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= PH_IDLE;
      state_r.requested    <= 1'b0;
      state_r.power_on     <= 1'b0;
      state_r.monitoring   <= 1'b0;
      state_r.pin_level    <= 1'b0;
      state_r.phase_count  <= '0;
      state_r.since_toggle <= '0;
      state_r.backoff_now  <= DEFAULT_BACKOFF;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.phase, res_r.believed_on, res_r.rx_monitor,
                       res_r.toggle_pin};

  // pin is low throughout the pulse
  a_low_pin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_LOW |-> !state_r.pin_level)
    else $error("toggle pin high during low pulse");

  // pin is high throughout settle
  a_high_pin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_HIGH |-> state_r.pin_level)
    else $error("toggle pin low during settle");

  // an empty result register never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule
